// ===== src/rrms_pkg.sv =====
package rrms_pkg;

	localparam int MAX_PAIRS      = 1048576;
	localparam int COEF_FRAC_BITS = 16;

	localparam int COEF_W       = 18;
	localparam int COORD_W      = 24;
	localparam int ROW_W        = 3 * COEF_W;
	localparam int PROD_W       = COEF_W + COORD_W;
	localparam int SH_W         = PROD_W - COEF_FRAC_BITS;
	localparam int DIFF_W       = COORD_W + 1;
	localparam int RES_W        = ((SH_W > DIFF_W) ? SH_W : DIFF_W) + 2;
	localparam int MAG_W        = (RES_W > 32) ? RES_W : 33;
	localparam int SQ_W         = 64;
	localparam int PSQ_W        = SQ_W + 2;
	localparam int ACC_W        = SQ_W + 3;
	localparam int PAIR_W       = $clog2(MAX_PAIRS + 1);
	localparam int OUT_PAIR_W   = 21;
	localparam int CFG_IDX_W    = 3;
	localparam int CFG_DATA_W   = ROW_W;
	localparam int Q_DEPTH      = 8;
	localparam int Q_AW         = $clog2(Q_DEPTH);
	localparam int Q_CNT_W      = $clog2(Q_DEPTH + 1);
	localparam int FRONT_STAGES = 5;
	localparam int CREDIT_W     = $clog2(Q_DEPTH + FRONT_STAGES + 1);
	localparam int DIV_STEPS    = SQ_W;
	localparam int DIV_CNT_W    = $clog2(DIV_STEPS);

	localparam logic [CFG_IDX_W-1:0] REG_ROT_ROW0 = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ROT_ROW1 = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_ROT_ROW2 = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SHIFT_X  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_SHIFT_Y  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_SHIFT_Z  = 3'd5;

	localparam logic [ROW_W-1:0] COEF_ONE     = ROW_W'(1) << COEF_FRAC_BITS;
	localparam logic [ROW_W-1:0] ROT_ROW0_RST = COEF_ONE;
	localparam logic [ROW_W-1:0] ROT_ROW1_RST = COEF_ONE << COEF_W;
	localparam logic [ROW_W-1:0] ROT_ROW2_RST = COEF_ONE << (2 * COEF_W);

	typedef struct packed {
		logic [PSQ_W-1:0] pair_sq;
		logic             sat;
		logic             last;
	} q_entry_t;

	typedef struct packed {
		logic     valid;
		q_entry_t entry;
	} q_push_t;

	typedef struct packed {
		logic     avail;
		q_entry_t entry;
	} q_head_t;

	typedef enum logic [2:0] {
		ST_ACC  = 3'b001,
		ST_DIV  = 3'b010,
		ST_HOLD = 3'b100
	} back_state_t;

endpackage

// ===== src/rrms_if.sv =====
interface rrms_pair_if;
	logic                                valid;
	logic                                ready;
	logic signed [rrms_pkg::COORD_W-1:0] ref_x;
	logic signed [rrms_pkg::COORD_W-1:0] ref_y;
	logic signed [rrms_pkg::COORD_W-1:0] ref_z;
	logic signed [rrms_pkg::COORD_W-1:0] src_x;
	logic signed [rrms_pkg::COORD_W-1:0] src_y;
	logic signed [rrms_pkg::COORD_W-1:0] src_z;
	logic                                last_pair;

	modport source (output valid, ref_x, ref_y, ref_z, src_x, src_y, src_z, last_pair,
		input ready);
	modport sink (input valid, ref_x, ref_y, ref_z, src_x, src_y, src_z, last_pair,
		output ready);
endinterface

interface rrms_res_if;
	logic                                valid;
	logic                                ready;
	logic [rrms_pkg::SQ_W-1:0]           mean_square;
	logic [rrms_pkg::OUT_PAIR_W-1:0]     pair_total;
	logic                                sum_saturated;

	modport source (output valid, mean_square, pair_total, sum_saturated, input ready);
	modport sink (input valid, mean_square, pair_total, sum_saturated, output ready);
endinterface

interface rrms_cfg_if;
	logic                              valid;
	logic                              ready;
	logic [rrms_pkg::CFG_IDX_W-1:0]    reg_index;
	logic [rrms_pkg::CFG_DATA_W-1:0]   wr_data;

	modport source (output valid, reg_index, wr_data, input ready);
	modport sink (input valid, reg_index, wr_data, output ready);
endinterface

// ===== src/rrms_front.sv =====
module rrms_front (
	input  logic                            clk,
	input  logic                            arst_n,
	rrms_cfg_if.sink                        cfg,
	rrms_pair_if.sink                       pairs,
	input  logic [rrms_pkg::Q_CNT_W-1:0]    q_count,
	output rrms_pkg::q_push_t               q_push
);

	logic [rrms_pkg::ROW_W-1:0]          row_q [3];
	logic signed [rrms_pkg::COORD_W-1:0] shift_q [3];

	logic v_s1, v_s2, v_s3, v_s4, v_s5;
	logic last_s1, last_s2, last_s3, last_s4, last_s5;

	logic signed [rrms_pkg::PROD_W-1:0] prod_s1 [3][3];
	logic signed [rrms_pkg::DIFF_W-1:0] diff_s1 [3];
	logic signed [rrms_pkg::RES_W-1:0]  res_s2 [3];
	logic [rrms_pkg::MAG_W-1:0]         mag_s3 [3];
	logic [rrms_pkg::SQ_W-1:0]          sq_s4 [3];
	logic                               sat_s4;
	logic [rrms_pkg::PSQ_W-1:0]         psq_s5;
	logic                               sat_s5;

	logic [rrms_pkg::CREDIT_W-1:0]       credit;
	logic                                accept;
	logic signed [rrms_pkg::COORD_W-1:0] src [3];
	logic signed [rrms_pkg::COORD_W-1:0] refp [3];
	logic signed [rrms_pkg::RES_W-1:0]   res_c [3];
	logic signed [rrms_pkg::SH_W-1:0]    sh_c [3][3];
	logic signed [rrms_pkg::RES_W-1:0]   neg_c [3];
	logic [2:0]                          over_c;

	// config
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q[0]   <= rrms_pkg::ROT_ROW0_RST;
			row_q[1]   <= rrms_pkg::ROT_ROW1_RST;
			row_q[2]   <= rrms_pkg::ROT_ROW2_RST;
			shift_q[0] <= '0;
			shift_q[1] <= '0;
			shift_q[2] <= '0;
		end else if (cfg.valid) begin
			unique case (cfg.reg_index)
				rrms_pkg::REG_ROT_ROW0: row_q[0] <= cfg.wr_data;
				rrms_pkg::REG_ROT_ROW1: row_q[1] <= cfg.wr_data;
				rrms_pkg::REG_ROT_ROW2: row_q[2] <= cfg.wr_data;
				rrms_pkg::REG_SHIFT_X:  shift_q[0] <= cfg.wr_data[rrms_pkg::COORD_W-1:0];
				rrms_pkg::REG_SHIFT_Y:  shift_q[1] <= cfg.wr_data[rrms_pkg::COORD_W-1:0];
				rrms_pkg::REG_SHIFT_Z:  shift_q[2] <= cfg.wr_data[rrms_pkg::COORD_W-1:0];
				default: ;
			endcase
		end
	end

	// credit: queue entries plus items still in flight
	assign credit = rrms_pkg::CREDIT_W'(q_count) + rrms_pkg::CREDIT_W'(v_s1)
		+ rrms_pkg::CREDIT_W'(v_s2) + rrms_pkg::CREDIT_W'(v_s3)
		+ rrms_pkg::CREDIT_W'(v_s4) + rrms_pkg::CREDIT_W'(v_s5);
	assign pairs.ready = credit < rrms_pkg::CREDIT_W'(rrms_pkg::Q_DEPTH);
	assign accept      = pairs.valid && pairs.ready;

	assign src[0]  = pairs.src_x;
	assign src[1]  = pairs.src_y;
	assign src[2]  = pairs.src_z;
	assign refp[0] = pairs.ref_x;
	assign refp[1] = pairs.ref_y;
	assign refp[2] = pairs.ref_z;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			v_s1 <= accept;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	// stage 1: products and translation minus reference
	always_ff @(posedge clk) begin
		last_s1 <= pairs.last_pair;
		for (int j = 0; j < 3; j++) begin
			diff_s1[j] <= rrms_pkg::DIFF_W'(shift_q[j]) - rrms_pkg::DIFF_W'(refp[j]);
			for (int k = 0; k < 3; k++) begin
				prod_s1[j][k] <= rrms_pkg::PROD_W'(
					$signed(row_q[j][k*rrms_pkg::COEF_W +: rrms_pkg::COEF_W]))
					* rrms_pkg::PROD_W'(src[k]);
			end
		end
	end

	// stage 2: residual components
	always_comb begin
		for (int j = 0; j < 3; j++) begin
			for (int k = 0; k < 3; k++) begin
				sh_c[j][k] = prod_s1[j][k][rrms_pkg::PROD_W-1:rrms_pkg::COEF_FRAC_BITS];
			end
			res_c[j] = rrms_pkg::RES_W'(diff_s1[j]) + rrms_pkg::RES_W'(sh_c[j][0])
				+ rrms_pkg::RES_W'(sh_c[j][1]) + rrms_pkg::RES_W'(sh_c[j][2]);
		end
	end

	always_ff @(posedge clk) begin
		last_s2 <= last_s1;
		for (int j = 0; j < 3; j++) begin
			res_s2[j] <= res_c[j];
		end
	end

	// stage 3: magnitudes
	always_comb begin
		for (int j = 0; j < 3; j++) begin
			neg_c[j] = -res_s2[j];
		end
	end

	always_ff @(posedge clk) begin
		last_s3 <= last_s2;
		for (int j = 0; j < 3; j++) begin
			mag_s3[j] <= rrms_pkg::MAG_W'(res_s2[j][rrms_pkg::RES_W-1] ?
				$unsigned(neg_c[j]) : $unsigned(res_s2[j]));
		end
	end

	// stage 4: squares, saturating past 32-bit magnitude
	always_comb begin
		for (int j = 0; j < 3; j++) begin
			over_c[j] = |mag_s3[j][rrms_pkg::MAG_W-1:32];
		end
	end

	always_ff @(posedge clk) begin
		last_s4 <= last_s3;
		sat_s4  <= |over_c;
		for (int j = 0; j < 3; j++) begin
			sq_s4[j] <= over_c[j] ? '1 : mag_s3[j][31:0] * mag_s3[j][31:0];
		end
	end

	// stage 5: squared length
	always_ff @(posedge clk) begin
		last_s5 <= last_s4;
		sat_s5  <= sat_s4;
		psq_s5  <= rrms_pkg::PSQ_W'(sq_s4[0]) + rrms_pkg::PSQ_W'(sq_s4[1])
			+ rrms_pkg::PSQ_W'(sq_s4[2]);
	end

	assign q_push.valid         = v_s5;
	assign q_push.entry.pair_sq = psq_s5;
	assign q_push.entry.sat     = sat_s5;
	assign q_push.entry.last    = last_s5;

endmodule

// ===== src/rrms_queue.sv =====
module rrms_queue (
	input  logic                            clk,
	input  logic                            arst_n,
	input  rrms_pkg::q_push_t               q_push,
	input  logic                            pop,
	output rrms_pkg::q_head_t               head,
	output logic [rrms_pkg::Q_CNT_W-1:0]    count
);

	rrms_pkg::q_entry_t           mem_q [rrms_pkg::Q_DEPTH];
	logic [rrms_pkg::Q_AW-1:0]    wptr_q;
	logic [rrms_pkg::Q_AW-1:0]    rptr_q;
	logic [rrms_pkg::Q_CNT_W-1:0] cnt_q;

	always_ff @(posedge clk) begin
		if (q_push.valid) begin
			mem_q[wptr_q] <= q_push.entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (q_push.valid) begin
				wptr_q <= wptr_q + 1'b1;
			end
			if (pop) begin
				rptr_q <= rptr_q + 1'b1;
			end
			if (q_push.valid && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !q_push.valid) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	assign head.avail = cnt_q != '0;
	assign head.entry = mem_q[rptr_q];
	assign count      = cnt_q;

endmodule

// ===== src/rrms_back.sv =====
module rrms_back (
	input  logic              clk,
	input  logic              arst_n,
	input  rrms_pkg::q_head_t head,
	output logic              pop,
	rrms_res_if.source        result
);

	rrms_pkg::back_state_t           state_q;
	logic [rrms_pkg::SQ_W-1:0]       sum_q;
	logic [rrms_pkg::PAIR_W-1:0]     cnt_q;
	logic                            sat_q;

	logic [rrms_pkg::SQ_W-1:0]       dq_q;
	logic [rrms_pkg::PAIR_W-1:0]     rem_q;
	logic [rrms_pkg::PAIR_W-1:0]     div_q;
	logic                            dsat_q;
	logic [rrms_pkg::DIV_CNT_W-1:0]  step_q;

	logic                            out_valid_q;
	logic [rrms_pkg::SQ_W-1:0]       out_mean_q;
	logic [rrms_pkg::OUT_PAIR_W-1:0] out_pairs_q;
	logic                            out_sat_q;

	logic [rrms_pkg::ACC_W-1:0]      acc_sum;
	logic                            acc_ovf;
	logic                            acc_sat;
	logic [rrms_pkg::SQ_W-1:0]       acc_val;
	logic [rrms_pkg::PAIR_W-1:0]     cnt_next;
	logic                            close;
	logic [rrms_pkg::PAIR_W:0]       trial;
	logic [rrms_pkg::PAIR_W:0]       diff;
	logic                            take;
	logic                            out_free;

	assign pop      = (state_q == rrms_pkg::ST_ACC) && head.avail;
	assign acc_sum  = rrms_pkg::ACC_W'(sum_q) + rrms_pkg::ACC_W'(head.entry.pair_sq);
	assign acc_ovf  = |acc_sum[rrms_pkg::ACC_W-1:rrms_pkg::SQ_W];
	assign acc_sat  = sat_q || head.entry.sat || acc_ovf;
	assign acc_val  = acc_ovf ? '1 : acc_sum[rrms_pkg::SQ_W-1:0];
	assign cnt_next = cnt_q + 1'b1;
	assign close    = head.entry.last
		|| (cnt_next >= rrms_pkg::PAIR_W'(rrms_pkg::MAX_PAIRS));

	// restoring divide, one quotient bit per cycle
	assign trial    = {rem_q, dq_q[rrms_pkg::SQ_W-1]};
	assign diff     = trial - {1'b0, div_q};
	assign take     = trial >= {1'b0, div_q};
	assign out_free = !out_valid_q || result.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= rrms_pkg::ST_ACC;
			sum_q   <= '0;
			cnt_q   <= '0;
			sat_q   <= 1'b0;
			step_q  <= '0;
		end else begin
			unique case (state_q)
				rrms_pkg::ST_ACC: begin
					if (pop) begin
						if (close) begin
							sum_q   <= '0;
							cnt_q   <= '0;
							sat_q   <= 1'b0;
							step_q  <= rrms_pkg::DIV_CNT_W'(rrms_pkg::DIV_STEPS - 1);
							state_q <= rrms_pkg::ST_DIV;
						end else begin
							sum_q <= acc_val;
							cnt_q <= cnt_next;
							sat_q <= acc_sat;
						end
					end
				end
				rrms_pkg::ST_DIV: begin
					step_q <= step_q - 1'b1;
					if (step_q == '0) begin
						state_q <= rrms_pkg::ST_HOLD;
					end
				end
				rrms_pkg::ST_HOLD: begin
					if (out_free) begin
						state_q <= rrms_pkg::ST_ACC;
					end
				end
				default: state_q <= rrms_pkg::ST_ACC;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == rrms_pkg::ST_ACC && pop && close) begin
			dq_q   <= acc_val;
			rem_q  <= '0;
			div_q  <= cnt_next;
			dsat_q <= acc_sat;
		end else if (state_q == rrms_pkg::ST_DIV) begin
			dq_q  <= {dq_q[rrms_pkg::SQ_W-2:0], take};
			rem_q <= take ? diff[rrms_pkg::PAIR_W-1:0] : trial[rrms_pkg::PAIR_W-1:0];
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == rrms_pkg::ST_HOLD && out_free) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == rrms_pkg::ST_HOLD && out_free) begin
			out_mean_q  <= dq_q;
			out_pairs_q <= rrms_pkg::OUT_PAIR_W'(div_q);
			out_sat_q   <= dsat_q;
		end
	end

	assign result.valid         = out_valid_q;
	assign result.mean_square   = out_mean_q;
	assign result.pair_total    = out_pairs_q;
	assign result.sum_saturated = out_sat_q;

endmodule

// ===== src/rigid_residual_mean_square.sv =====
// channel  modport  role
// cfg      sink     register writes: reg_index, wr_data; always ready
// pairs    sink     point pairs: ref_x/y/z, src_x/y/z, last_pair
// result   source   per set: mean_square, pair_total, sum_saturated
//
// Within a set one pair is taken per cycle while the input does not stall; a taken pair
// passes the front pipeline stages and the queue before it is accumulated. Closing a set runs
// the 64-step serial divider; the next pair is accumulated only after the divide and the
// hand-off to the result register. Input stalls once queued plus in-flight items reach 8. Reset
// leaves no memory to clear; the result register holds one set while the next set streams in.
module rigid_residual_mean_square (
	input  logic       clk,
	input  logic       arst_n,
	rrms_cfg_if.sink   cfg,
	rrms_pair_if.sink  pairs,
	rrms_res_if.source result
);

	rrms_pkg::q_push_t                 q_push;
	rrms_pkg::q_head_t                 q_head;
	logic                              q_pop;
	logic [rrms_pkg::Q_CNT_W-1:0]      q_count;

	rrms_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg),
		.pairs   (pairs),
		.q_count (q_count),
		.q_push  (q_push)
	);

	rrms_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.q_push (q_push),
		.pop    (q_pop),
		.head   (q_head),
		.count  (q_count)
	);

	rrms_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.head   (q_head),
		.pop    (q_pop),
		.result (result)
	);

endmodule
